// ===== hdl/bsppl_pkg.sv =====
package bsppl_pkg;

    // Commands carried in an input request
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOCATE = 1'b1;

    // Default node table depth
    localparam int NODE_COUNT_DEF = 4096;

    // Input request payload
    typedef struct packed {
        logic               command;
        logic        [11:0] node_index;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [23:0] plane_offset;
        logic signed [15:0] front_child;
        logic signed [15:0] back_child;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
    } t_in;

    // Result payload
    typedef struct packed {
        logic [14:0] leaf_number;
        logic        walk_fault;
    } t_out;

    // One node table entry
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [23:0] plane_offset;
        logic signed [15:0] front_child;
        logic signed [15:0] back_child;
    } t_node;

endpackage

// ===== hdl/bsp_point_leaf_lookup.sv =====
// Channel  | Valid       | Ready       | Payload
// ---------+-------------+-------------+--------------------------------
// request  | i_in_valid  | o_in_ready  | i_in  (write node / locate)
// result   | o_out_valid | i_out_ready | o_out (leaf number, fault)
//
// A locate request visits nodes from node 0; each node takes one table read,
// three passes through the shared 16x24 multiplier and one compare.
// Reset (synchronous, active low) clears the sequencer and the result valid flag;
// the node table is not cleared and must be written before it is walked.
// A waiting result does not stop new requests; a finished walk holds in its
// last step until the result register is free.
module bsp_point_leaf_lookup
    import bsppl_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SW = $clog2(NODE_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_DECIDE
    } t_state;

    t_node               r_mem [NODE_COUNT];
    t_node               r_rd;

    t_state              r_state,     n_state;
    logic [AW-1:0]       r_pos,       n_pos;
    logic [SW-1:0]       r_steps,     n_steps;
    logic [1:0]          r_term,      n_term;
    logic signed [39:0]  r_prod,      n_prod;
    logic signed [41:0]  r_acc,       n_acc;
    logic signed [23:0]  r_px,        n_px;
    logic signed [23:0]  r_py,        n_py;
    logic signed [23:0]  r_pz,        n_pz;
    logic                r_out_valid, n_out_valid;
    t_out                r_out,       n_out;

    logic                in_acc;
    logic                wr_en;
    logic signed [15:0]  mul_a;
    logic signed [23:0]  mul_b;
    logic signed [41:0]  dval;
    logic                go_back;
    logic signed [15:0]  child;
    logic                slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign wr_en       = in_acc && (i_in.command == CMD_WRITE)
                         && (17'(i_in.node_index) < 17'(NODE_COUNT));
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign slot_free   = !r_out_valid || i_out_ready;

    // Store written nodes and read the node being visited
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(i_in.node_index)] <= '{
                normal_x:     i_in.normal_x,
                normal_y:     i_in.normal_y,
                normal_z:     i_in.normal_z,
                plane_offset: i_in.plane_offset,
                front_child:  i_in.front_child,
                back_child:   i_in.back_child
            };
        end
        r_rd <= r_mem[r_pos];
    end

    // Select the operands of the shared multiplier
    always_comb begin
        case (r_term)
            2'd0:    begin mul_a = r_rd.normal_x; mul_b = r_px; end
            2'd1:    begin mul_a = r_rd.normal_y; mul_b = r_py; end
            default: begin mul_a = r_rd.normal_z; mul_b = r_pz; end
        endcase
    end

    // Final plane distance and child choice
    assign dval    = r_acc + {{2{r_prod[39]}}, r_prod};
    assign go_back = dval[41] || (dval == '0);
    assign child   = go_back ? r_rd.back_child : r_rd.front_child;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_steps     = r_steps;
        n_term      = r_term;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_px        = r_px;
        n_py        = r_py;
        n_pz        = r_pz;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.command == CMD_LOCATE)) begin
                    n_px    = i_in.point_x;
                    n_py    = i_in.point_y;
                    n_pz    = i_in.point_z;
                    n_pos   = '0;
                    n_steps = SW'(1);
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_term  = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod = 40'(mul_a * mul_b);
                if (r_term == 2'd0) begin
                    n_acc = 42'sd0 - {{4{r_rd.plane_offset[23]}}, r_rd.plane_offset, 14'b0};
                end else begin
                    n_acc = r_acc + {{2{r_prod[39]}}, r_prod};
                end
                n_term = r_term + 2'd1;
                if (r_term == 2'd2) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (child[15]) begin
                    // Leaf reached: hold until the result register is free
                    if (slot_free) begin
                        n_out_valid       = 1'b1;
                        n_out.leaf_number = ~child[14:0];
                        n_out.walk_fault  = 1'b0;
                        n_state           = S_IDLE;
                    end
                end else if ((17'(child) >= 17'(NODE_COUNT))
                             || (17'(r_steps) >= 17'(NODE_COUNT))) begin
                    // Walk left the table or ran too long
                    if (slot_free) begin
                        n_out_valid       = 1'b1;
                        n_out.leaf_number = '0;
                        n_out.walk_fault  = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_pos   = AW'(child[14:0]);
                    n_steps = r_steps + SW'(1);
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_steps     <= '0;
            r_term      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_steps     <= n_steps;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_px   <= n_px;
        r_py   <= n_py;
        r_pz   <= n_pz;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // Visited node always lies inside the table
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (17'(r_pos) < 17'(NODE_COUNT)))
        else $error("walk position outside node table");

    // Step count never passes the node count
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (17'(r_steps) <= 17'(NODE_COUNT)))
        else $error("walk step count exceeds node count");

    // A faulted walk reports leaf zero
    a_fault_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.walk_fault) |-> (o_out.leaf_number == '0))
        else $error("faulted result carries a leaf number");

    // A result is only produced when leaving the compare step
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DECIDE) && (r_state == S_IDLE))
        else $error("result raised outside the compare step");

    // Multiplier pass counter stays within three terms
    a_term_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_term != 2'd3))
        else $error("multiplier pass counter overran");
`endif

endmodule

// ===== dv/bsp_point_leaf_lookup_tb.sv =====
`timescale 1ns / 1ps

module bsp_point_leaf_lookup_tb;
    import bsppl_pkg::*;

    localparam int NODE_COUNT   = NODE_COUNT_DEF;
    localparam int ITEM_TARGET  = 1850;
    localparam int LONG_WALK    = 64;
    localparam int IDLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_TREE     = 256;
    // node table copies: one follows accepted requests, one follows generation
    localparam int DUT_BANK     = 0;
    localparam int PLAN_BANK    = 1;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    t_in   pending_reqs [$];
    t_out  leaf_expect_q [$];
    t_node node_store [2][NODE_COUNT];
    bit    node_written [NODE_COUNT];
    int    tree_ids [MAX_TREE];
    bit    loops_on        = 1'b0;
    int    long_walks_left = 12;
    int    fail_count      = 0;
    int    idle_cycles     = 0;

    bit    in_fire  = 1'b0;
    bit    out_fire = 1'b0;
    t_out  exp_res;
    int    walk_len;
    bit    walk_safe;

    t_in   drv_req   = '0;
    bit    drv_valid = 1'b0;
    int    drv_gap   = 0;
    int    drv_quiet = 0;
    int    out_stall = 0;
    int    out_quiet = 0;

    bsp_point_leaf_lookup #(
        .NODE_COUNT (NODE_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_node node_of(input t_in req);
        t_node nd;
        nd.normal_x     = req.normal_x;
        nd.normal_y     = req.normal_y;
        nd.normal_z     = req.normal_z;
        nd.plane_offset = req.plane_offset;
        nd.front_child  = req.front_child;
        nd.back_child   = req.back_child;
        return nd;
    endfunction

    // Walk the tree from node 0 and work out the leaf or the fault
    function automatic void trace_walk(input int bank, input t_in req, output t_out res,
                                       output int steps, output bit safe);
        longint child;
        longint side;
        t_node  nd;
        bit     done;
        child = 0;
        steps = 0;
        safe  = 1'b1;
        done  = 1'b0;
        res   = '0;
        while (!done) begin
            if (child < 0) begin
                res.leaf_number = 15'(-1 - child);
                done = 1'b1;
            end else if (child >= NODE_COUNT || steps >= NODE_COUNT) begin
                res.walk_fault = 1'b1;
                done = 1'b1;
            end else if (bank == PLAN_BANK && !node_written[child[11:0]]) begin
                // never ask the block to read an entry that holds nothing
                safe = 1'b0;
                done = 1'b1;
            end else begin
                nd = node_store[bank][child[11:0]];
                steps++;
                // exact Q.14 plane test, distance scaled up by 2^14
                side = longint'($signed(nd.normal_x)) * longint'($signed(req.point_x))
                     + longint'($signed(nd.normal_y)) * longint'($signed(req.point_y))
                     + longint'($signed(nd.normal_z)) * longint'($signed(req.point_z))
                     - longint'($signed(nd.plane_offset)) * 64'sd16384;
                child = (side <= 0) ? longint'($signed(nd.back_child))
                                    : longint'($signed(nd.front_child));
            end
        end
    endfunction

    // Draw a wait between 0 and 5, with stretches of no waiting at all
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(10, 40);
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic t_in random_request(input bit near_origin);
        t_in req;
        req.command      = CMD_WRITE;
        req.node_index   = 12'($urandom);
        req.normal_x     = ($urandom_range(0, 9) == 0) ? '0 : 16'($urandom);
        req.normal_y     = ($urandom_range(0, 9) == 0) ? '0 : 16'($urandom);
        req.normal_z     = ($urandom_range(0, 9) == 0) ? '0 : 16'($urandom);
        req.front_child  = 16'($urandom);
        req.back_child   = 16'($urandom);
        if (near_origin) begin
            req.plane_offset = 24'(int'($urandom_range(0, 8191)) - 4096);
            req.point_x      = 24'(int'($urandom_range(0, 2047)) - 1024);
            req.point_y      = 24'(int'($urandom_range(0, 2047)) - 1024);
            req.point_z      = 24'(int'($urandom_range(0, 2047)) - 1024);
        end else begin
            req.plane_offset = 24'($urandom);
            req.point_x      = 24'($urandom);
            req.point_y      = 24'($urandom);
            req.point_z      = 24'($urandom);
        end
        return req;
    endfunction

    function automatic t_in axis_node(input int idx, input int offset,
                                      input int f_child, input int b_child);
        t_in req;
        req              = random_request(1'b0);
        req.node_index   = 12'(idx);
        req.normal_x     = 16'sd16384;
        req.normal_y     = '0;
        req.normal_z     = '0;
        req.plane_offset = 24'(offset);
        req.front_child  = 16'(f_child);
        req.back_child   = 16'(b_child);
        return req;
    endfunction

    function automatic t_in point_at(input int x, input int y, input int z);
        t_in req;
        req         = random_request(1'b0);
        req.point_x = 24'(x);
        req.point_y = 24'(y);
        req.point_z = 24'(z);
        return req;
    endfunction

    function automatic void queue_write(input t_in req);
        req.command = CMD_WRITE;
        node_store[PLAN_BANK][req.node_index] = node_of(req);
        node_written[req.node_index] = 1'b1;
        pending_reqs.push_back(req);
    endfunction

    // Queue a locate only if its walk stays on written nodes; ration long walks
    function automatic void queue_locate(input t_in req);
        t_out res;
        int   steps;
        bit   safe;
        req.command = CMD_LOCATE;
        trace_walk(PLAN_BANK, req, res, steps, safe);
        if (!safe) return;
        if (steps > LONG_WALK) begin
            if (long_walks_left == 0) return;
            long_walks_left--;
        end
        pending_reqs.push_back(req);
    endfunction

    // Pick a child for tree node j: a leaf, a deeper node, past the table or a loop
    function automatic logic signed [15:0] pick_child(input int j, input int k);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && j + 1 < k) return 16'(tree_ids[$urandom_range(j + 1, k - 1)]);
        if (roll >= 40 && roll < 44) return 16'($urandom_range(NODE_COUNT, 32767));
        if (roll >= 44 && roll < 48 && loops_on) return 16'(tree_ids[$urandom_range(0, j)]);
        return 16'(-1 - int'($urandom_range(0, 32767)));
    endfunction

    // Drive requests from the pending queue, one wait drawn per request
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                drv_valid = 1'b0;
                drv_gap   = draw_wait(drv_quiet);
            end
            if (!drv_valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_reqs.size() > 0) begin
                    drv_req   = pending_reqs.pop_front();
                    drv_valid = 1'b1;
                end
            end
            i_in_valid <= drv_valid;
            i_in       <= drv_req;
        end
    end

    // Stall the result channel for a drawn number of cycles after each result
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) out_stall = draw_wait(out_quiet);
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Sample both handshakes, predict each request and check each result
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (in_fire) begin
            if (i_in.command == CMD_WRITE) begin
                node_store[DUT_BANK][i_in.node_index] = node_of(i_in);
            end else begin
                trace_walk(DUT_BANK, i_in, exp_res, walk_len, walk_safe);
                leaf_expect_q.push_back(exp_res);
            end
        end
        if (out_fire) begin
            if (leaf_expect_q.size() == 0) begin
                $error("result with no locate request waiting: leaf_number %0d walk_fault %0d",
                       o_out.leaf_number, o_out.walk_fault);
                fail_count++;
            end else begin
                exp_res = leaf_expect_q.pop_front();
                if (o_out.leaf_number !== exp_res.leaf_number) begin
                    $error("leaf_number: expected %0d, got %0d",
                           exp_res.leaf_number, o_out.leaf_number);
                    fail_count++;
                end
                if (o_out.walk_fault !== exp_res.walk_fault) begin
                    $error("walk_fault: expected %0d, got %0d",
                           exp_res.walk_fault, o_out.walk_fault);
                    fail_count++;
                end
            end
        end
        // watchdog: count cycles with no handshake on either channel
        if (in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_in req;
        int  k;
        int  n_loc;
        int  m;
        int  j;
        int  roll;

        // small hand-built tree: node 0 splits on x, node 1 has extreme planes,
        // node 2 leaves the table behind, node 3 loops on itself
        queue_write(axis_node(0, 0, 1, 2));
        req              = random_request(1'b0);
        req.node_index   = 12'd1;
        req.normal_x     = 16'sd32767;
        req.normal_y     = -16'sd32768;
        req.normal_z     = 16'sd32767;
        req.plane_offset = 24'sd8388607;
        req.front_child  = -16'sd1;
        req.back_child   = -16'sd32768;
        queue_write(req);
        queue_write(axis_node(2, -256, 3, NODE_COUNT));
        queue_write(axis_node(3, -128, 3, 32767));
        req              = random_request(1'b0);
        req.node_index   = 12'd4095;
        req.normal_x     = -16'sd32768;
        req.normal_y     = -16'sd32768;
        req.normal_z     = -16'sd32768;
        req.plane_offset = -24'sd8388608;
        queue_write(req);

        queue_locate(point_at(0, 0, 0));
        queue_locate(point_at(-8388608, 8388607, 8388607));
        queue_locate(point_at(-192, 0, 0));
        queue_locate(point_at(8388607, -8388608, 8388607));
        queue_locate(point_at(1, 8388607, -8388608));
        queue_locate(point_at(1, 0, 0));

        // flip node 1 to the opposite extremes
        req              = random_request(1'b0);
        req.node_index   = 12'd1;
        req.normal_x     = -16'sd32768;
        req.normal_y     = 16'sd32767;
        req.normal_z     = -16'sd32768;
        req.plane_offset = -24'sd8388608;
        req.front_child  = -16'sd32768;
        req.back_child   = -16'sd1;
        queue_write(req);
        queue_locate(point_at(1, 0, 0));
        queue_locate(point_at(8388607, 8388607, 8388607));

        // degenerate plane at node 0: the plane test is exactly zero, so take back
        req              = random_request(1'b0);
        req.node_index   = 12'd0;
        req.normal_x     = '0;
        req.normal_y     = '0;
        req.normal_z     = '0;
        req.plane_offset = '0;
        req.front_child  = -16'sd5;
        req.back_child   = -16'sd9;
        queue_write(req);
        queue_locate(point_at(3, -7, 11));
        queue_locate(point_at(-8388608, -8388608, -8388608));

        // random trees rooted at node 0, each followed by a burst of locates and occasional writes
        while (pending_reqs.size() < ITEM_TARGET) begin
            k        = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                                   : $urandom_range(1, 24);
            loops_on = ($urandom_range(0, 3) == 0);
            tree_ids[0] = 0;
            for (j = 1; j < k; j++) tree_ids[j] = $urandom_range(1, NODE_COUNT - 1);
            for (j = 0; j < k; j++) begin
                req             = random_request(1'b0);
                req.node_index  = 12'(tree_ids[j]);
                req.front_child = pick_child(j, k);
                req.back_child  = pick_child(j, k);
                queue_write(req);
                // now and then locate against a half-built tree
                if ($urandom_range(0, 9) == 0) queue_locate(random_request($urandom_range(0, 9) < 3));
            end
            n_loc = $urandom_range(5, 30);
            for (j = 0; j < n_loc; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    m               = $urandom_range(0, k - 1);
                    req             = random_request(1'b0);
                    req.node_index  = 12'(tree_ids[m]);
                    req.front_child = pick_child(m, k);
                    req.back_child  = pick_child(m, k);
                    queue_write(req);
                end else if (roll < 12) begin
                    queue_write(random_request(1'b0));
                end else begin
                    queue_locate(random_request($urandom_range(0, 9) < 3));
                end
            end
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: every request taken, every result back, then a short tail
        while (pending_reqs.size() != 0 || drv_valid || leaf_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && leaf_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
